[hw/rtl/utf8d_pkg.sv]
package utf8d_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EOF      = 3'd1;
    localparam logic [2:0] ST_BAD_LEAD = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    localparam logic REG_LOSSY_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic [7:0] byte_fourth;
        logic [2:0] avail_count;
    } in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  status;
        logic [2:0]  advance_bytes;
        logic        deliver;
    } out_t;

    typedef struct packed {
        logic        eof;
        logic        err;
        logic [2:0]  status;
        logic [2:0]  adv;
        logic [2:0]  len;
        logic [20:0] cp;
    } front_t;

    typedef struct packed {
        logic        err;
        logic [20:0] cp;
        logic [2:0]  status;
        logic [2:0]  adv;
    } mid_t;

endpackage

[hw/rtl/utf8_char_decoder_top.sv]
// UTF-8 character decoder.
// Each input transaction carries a window of four bytes at the feeder's read
// position and the count of bytes still available. Each one produces exactly
// one output transaction with the code point, a status code and the number
// of bytes the feeder must advance. Malformed input yields U+FFFD; in lossy
// mode such results carry deliver low so the feeder simply skips them.
// The lossy_mode register sits at byte address 0 of the APB-style port and
// must only be written while no transaction is in flight.
// The stages are lead decode and continuation checks, range checks, and the
// output register, which drives out_valid.
// Throughput is one character per cycle while out_stall is low; each stage
// holds one transaction. When the receiver raises out_stall, the output
// register holds its data and the stages behind it keep filling until each
// holds a transaction; only then is in_stall raised. Nothing is dropped or
// repeated. Reset clears all valid bits and sets lossy_mode to zero.
module utf8_char_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  utf8d_pkg::in_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output utf8d_pkg::out_t                 out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utf8d_pkg::PADDR_W-1:0]   paddr,
    input  logic [utf8d_pkg::PDATA_W-1:0]   pwdata,
    output logic [utf8d_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import utf8d_pkg::*;

    logic   lossy_reg;
    logic   s1_valid_reg;
    logic   s2_valid_reg;
    logic   s3_valid_reg;
    front_t s1_reg;
    mid_t   s2_reg;
    mid_t   s2_next;
    out_t   s3_reg;
    out_t   s3_next;
    front_t front;
    logic   s1_ready;
    logic   s2_ready;
    logic   s3_ready;
    logic   cfg_write;
    logic   range_bad;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = {{(PDATA_W-1){1'b0}}, lossy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lossy_reg <= 1'b0;
        end
        else if (cfg_write && paddr[PADDR_W-1] == REG_LOSSY_MODE)
        begin
            lossy_reg <= pwdata[0];
        end
    end

    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    utf8d_front u_front (
        .item  (in_data),
        .front (front)
    );

    always_comb
    begin
        range_bad = ((s1_reg.len == 3'd2) && (s1_reg.cp < 21'h80))
                 || ((s1_reg.len == 3'd3) && (s1_reg.cp < 21'h800))
                 || ((s1_reg.len == 3'd4) && (s1_reg.cp < 21'h10000))
                 || ((s1_reg.cp >= 21'hD800) && (s1_reg.cp < 21'hE000))
                 || (s1_reg.cp > 21'h10FFFF);
        s2_next.err = s1_reg.err;
        s2_next.cp = s1_reg.cp;
        s2_next.status = s1_reg.status;
        s2_next.adv = s1_reg.adv;
        if (s1_reg.eof)
        begin
            s2_next.cp = 21'd0;
        end
        else if (s1_reg.err)
        begin
            s2_next.cp = REPLACEMENT_CP;
        end
        else if (range_bad)
        begin
            s2_next.err = 1'b1;
            s2_next.cp = REPLACEMENT_CP;
            s2_next.status = ST_INVALID;
            s2_next.adv = s1_reg.len;
        end
    end

    always_comb
    begin
        s3_next.code_point = s2_reg.cp;
        s3_next.status = s2_reg.status;
        s3_next.advance_bytes = s2_reg.adv;
        s3_next.deliver = s2_reg.err ? !lossy_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= front;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data = s3_reg;

endmodule

[hw/rtl/utf8d_front.sv]
module utf8d_front (
    input  utf8d_pkg::in_t    item,
    output utf8d_pkg::front_t front
);
    import utf8d_pkg::*;

    logic [2:0] avail;
    logic [2:0] len;
    logic       bad_lead;
    logic [3:1] cont_ok;
    logic [20:0] cp;

    always_comb
    begin
        avail = item.avail_count[2] ? 3'd4 : item.avail_count;
        bad_lead = 1'b0;
        len = 3'd1;
        cp = {13'd0, item.byte_first};
        if (item.byte_first[7] == 1'b0)
        begin
            len = 3'd1;
            cp = {13'd0, item.byte_first};
        end
        else if (item.byte_first[7:5] == 3'b110)
        begin
            len = 3'd2;
            cp = {10'd0, item.byte_first[4:0], item.byte_second[5:0]};
        end
        else if (item.byte_first[7:4] == 4'b1110)
        begin
            len = 3'd3;
            cp = {5'd0, item.byte_first[3:0], item.byte_second[5:0],
                  item.byte_third[5:0]};
        end
        else if (item.byte_first[7:3] == 5'b11110)
        begin
            len = 3'd4;
            cp = {item.byte_first[2:0], item.byte_second[5:0],
                  item.byte_third[5:0], item.byte_fourth[5:0]};
        end
        else
        begin
            bad_lead = 1'b1;
        end

        cont_ok[1] = item.byte_second[7:6] == 2'b10;
        cont_ok[2] = item.byte_third[7:6] == 2'b10;
        cont_ok[3] = item.byte_fourth[7:6] == 2'b10;

        front.eof = 1'b0;
        front.err = 1'b0;
        front.status = ST_OK;
        front.adv = len;
        front.len = len;
        front.cp = cp;

        if (avail == 3'd0)
        begin
            front.eof = 1'b1;
            front.status = ST_EOF;
            front.adv = 3'd0;
        end
        else if (bad_lead)
        begin
            front.err = 1'b1;
            front.status = ST_BAD_LEAD;
            front.adv = 3'd1;
        end
        else if (avail < len)
        begin
            front.err = 1'b1;
            front.status = ST_TRUNC;
            front.adv = 3'd1;
        end
        else if (len > 3'd1 && !cont_ok[1])
        begin
            front.err = 1'b1;
            front.status = ST_INVALID;
            front.adv = 3'd1;
        end
        else if (len > 3'd2 && !cont_ok[2])
        begin
            front.err = 1'b1;
            front.status = ST_INVALID;
            front.adv = 3'd2;
        end
        else if (len > 3'd3 && !cont_ok[3])
        begin
            front.err = 1'b1;
            front.status = ST_INVALID;
            front.adv = 3'd3;
        end
    end

endmodule

[hw/rtl/utf8d_checker.sv]
module utf8d_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  utf8d_pkg::out_t               out_data,
    input  logic [utf8d_pkg::PDATA_W-1:0] prdata
);
    import utf8d_pkg::*;

    // A stalled output transaction stays presented.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A good character is always delivered and moves the read position.
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK |->
            out_data.deliver && out_data.advance_bytes != 3'd0)
        else $error("good character not delivered or zero advance");

    // End of input reports code point zero and does not advance.
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EOF |->
            out_data.code_point == 21'd0 && out_data.advance_bytes == 3'd0
            && out_data.deliver)
        else $error("bad end-of-input result");

    // Errors carry the replacement character and follow the lossy setting.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK && out_data.status != ST_EOF |->
            out_data.code_point == REPLACEMENT_CP
            && out_data.deliver == !prdata[0]
            && out_data.advance_bytes != 3'd0)
        else $error("bad error result");

endmodule

bind utf8_char_decoder_top utf8d_checker u_utf8d_checker (.*);

[dv/utf8_char_decoder_top_tb.sv]
module utf8_char_decoder_top_tb;
    import utf8d_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_t                in_data  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_t               out_data;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    out_t expected_chars[$];
    logic lossy_shadow = 1'b0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;
    bit   in_offering  = 1'b0;
    int   burst_left   = 1;
    int   max_gap      = 0;
    int   stall_pct    = 0;
    int   stall_span   = 0;
    int   hold_left    = 0;
    bit   hold_request = 1'b0;

    utf8_char_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_t decode_char(in_t w, logic lossy);
        logic [7:0]  bytes_in [4];
        logic [2:0]  avail;
        logic [2:0]  seq_len;
        logic [20:0] cp;
        out_t        r;
        int          i;
        bytes_in[0] = w.byte_first;
        bytes_in[1] = w.byte_second;
        bytes_in[2] = w.byte_third;
        bytes_in[3] = w.byte_fourth;
        avail = (w.avail_count > 3'd4) ? 3'd4 : w.avail_count;
        r.code_point    = REPLACEMENT_CP;
        r.deliver       = !lossy;
        r.status        = ST_INVALID;
        r.advance_bytes = 3'd0;
        if (avail == 3'd0)
        begin
            r.code_point    = '0;
            r.status        = ST_EOF;
            r.advance_bytes = 3'd0;
            r.deliver       = 1'b1;
            return r;
        end
        if (!bytes_in[0][7])
        begin
            cp      = 21'(bytes_in[0][6:0]);
            seq_len = 3'd1;
        end
        else if (bytes_in[0][7:5] == 3'b110)
        begin
            cp      = 21'(bytes_in[0][4:0]);
            seq_len = 3'd2;
        end
        else if (bytes_in[0][7:4] == 4'b1110)
        begin
            cp      = 21'(bytes_in[0][3:0]);
            seq_len = 3'd3;
        end
        else if (bytes_in[0][7:3] == 5'b11110)
        begin
            cp      = 21'(bytes_in[0][2:0]);
            seq_len = 3'd4;
        end
        else
        begin
            r.status        = ST_BAD_LEAD;
            r.advance_bytes = 3'd1;
            return r;
        end
        if (avail < seq_len)
        begin
            r.status        = ST_TRUNC;
            r.advance_bytes = 3'd1;
            return r;
        end
        for (i = 1; i < seq_len; i++)
        begin
            if (bytes_in[i][7:6] != 2'b10)
            begin
                r.status        = ST_INVALID;
                r.advance_bytes = 3'(i);
                return r;
            end
            cp = (cp << 6) | 21'(bytes_in[i][5:0]);
        end
        if ((seq_len == 3'd2 && cp < 21'h80) ||
            (seq_len == 3'd3 && cp < 21'h800) ||
            (seq_len == 3'd4 && cp < 21'h10000) ||
            (cp >= 21'hD800 && cp < 21'hE000) ||
            (cp > 21'h10FFFF))
        begin
            r.status        = ST_INVALID;
            r.advance_bytes = seq_len;
            return r;
        end
        r.code_point    = cp;
        r.status        = ST_OK;
        r.advance_bytes = seq_len;
        r.deliver       = 1'b1;
        return r;
    endfunction

    function automatic in_t encode_scalar(logic [20:0] cp, int n);
        in_t w;
        w.byte_first  = 8'($urandom);
        w.byte_second = 8'($urandom);
        w.byte_third  = 8'($urandom);
        w.byte_fourth = 8'($urandom);
        w.avail_count = 3'(n);
        case (n)
            1: w.byte_first = {1'b0, cp[6:0]};
            2:
            begin
                w.byte_first  = {3'b110, cp[10:6]};
                w.byte_second = {2'b10, cp[5:0]};
            end
            3:
            begin
                w.byte_first  = {4'b1110, cp[15:12]};
                w.byte_second = {2'b10, cp[11:6]};
                w.byte_third  = {2'b10, cp[5:0]};
            end
            default:
            begin
                w.byte_first  = {5'b11110, cp[20:18]};
                w.byte_second = {2'b10, cp[17:12]};
                w.byte_third  = {2'b10, cp[11:6]};
                w.byte_fourth = {2'b10, cp[5:0]};
            end
        endcase
        return w;
    endfunction

    // Mostly well-formed characters; the rest is noise and broken sequences.
    function automatic in_t random_window();
        in_t         w;
        int          n;
        int          kind;
        int          pos;
        logic [1:0]  top2;
        logic [20:0] cp;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, 4);
        case (n)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp < 21'hE000)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        w = encode_scalar(cp, n);
        w.avail_count = 3'($urandom_range(n, 7));
        if (kind < 70)
            return w;
        case (kind % 7)
            0: w = in_t'({$urandom, 3'($urandom)});
            1: w.avail_count = 3'($urandom_range(0, n - 1));
            2:
            begin
                if (n > 1)
                begin
                    pos = $urandom_range(1, n - 1);
                    case ($urandom_range(0, 2))
                        0: top2 = 2'b00;
                        1: top2 = 2'b01;
                        default: top2 = 2'b11;
                    endcase
                    w[34 - 8 * pos -: 8] = {top2, 6'($urandom)};
                end
                else
                    w.byte_first = 8'($urandom_range('h80, 'hBF));
            end
            3:
            begin
                n = $urandom_range(2, 4);
                if (n == 2)
                    cp = 21'($urandom_range(0, 'h7F));
                else if (n == 3)
                    cp = 21'($urandom_range(0, 'h7FF));
                else
                    cp = 21'($urandom_range(0, 'hFFFF));
                w = encode_scalar(cp, n);
                w.avail_count = 3'($urandom_range(n, 7));
            end
            4:
            begin
                w = encode_scalar(21'($urandom_range('hD800, 'hDFFF)), 3);
                w.avail_count = 3'($urandom_range(3, 7));
            end
            5:
            begin
                w = encode_scalar(21'($urandom_range('h110000, 'h1FFFFF)), 4);
                w.avail_count = 3'($urandom_range(4, 7));
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    w.byte_first = 8'($urandom_range('h80, 'hBF));
                else
                    w.byte_first = 8'($urandom_range('hF8, 'hFF));
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic send_window(in_t w);
        int gap;
        in_data     <= w;
        in_valid    <= 1'b1;
        in_offering = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_chars.push_back(decode_char(w, lossy_shadow));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (max_gap > 0)
            begin
                gap = $urandom_range(1, max_gap);
                in_valid    <= 1'b0;
                in_offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [7:0] b3, logic [2:0] avail);
        in_t w;
        w.byte_first  = b0;
        w.byte_second = b1;
        w.byte_third  = b2;
        w.byte_fourth = b3;
        w.avail_count = avail;
        send_window(w);
    endtask

    task automatic wait_drained();
        if (in_offering)
        begin
            in_valid    <= 1'b0;
            in_offering = 1'b0;
        end
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_lossy(logic value);
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_LOSSY_MODE);
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        lossy_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== PDATA_W'(value))
            report_mismatch($sformatf("lossy_mode readback: expected %h, got %h",
                                      PDATA_W'(value), rd));
    endtask

    task automatic test_directed_corners();
        wait_drained();
        write_lossy(1'b0);
        max_gap = 2;
        send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        send_bytes(8'h7F, 8'hFF, 8'h00, 8'hFF, 3'd4);
        send_bytes(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hDF, 8'hBF, 8'h00, 8'h00, 3'd7);
        send_bytes(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
        send_bytes(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd5);
        send_bytes(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3);
        send_bytes(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3);
        send_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
        send_bytes(8'hEE, 8'h80, 8'h80, 8'h00, 3'd4);
        send_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
        send_bytes(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd6);
        send_bytes(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
        send_bytes(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);
        send_bytes(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
        send_bytes(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4);
        send_bytes(8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4);
        send_bytes(8'hE2, 8'h82, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hF0, 8'h41, 8'h41, 8'h41, 3'd1);
        send_bytes(8'hC3, 8'h41, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hE2, 8'h82, 8'h41, 8'h00, 3'd3);
        send_bytes(8'hF0, 8'h9F, 8'h98, 8'hC0, 3'd4);
    endtask

    task automatic test_lossy_errors();
        wait_drained();
        write_lossy(1'b1);
        max_gap = 3;
        send_bytes(8'h80, 8'h00, 8'h00, 8'h00, 3'd1);
        send_bytes(8'hE2, 8'h82, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hC3, 8'h41, 8'h00, 8'h00, 3'd2);
        send_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
        send_bytes(8'h41, 8'h00, 8'h00, 8'h00, 3'd1);
        send_bytes(8'hFF, 8'h00, 8'h00, 8'h00, 3'd0);
    endtask

    task automatic test_random(logic mode, int count);
        int k;
        wait_drained();
        write_lossy(mode);
        for (k = 0; k < count; k++)
        begin
            if (k % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: max_gap = 0;
                    1: max_gap = 3;
                    default: max_gap = 8;
                endcase
            end
            send_window(random_window());
        end
    endtask

    task automatic test_backpressure();
        int k;
        wait_drained();
        max_gap = 0;
        hold_request = 1'b1;
        for (k = 0; k < 40; k++)
            send_window(random_window());
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_span = $urandom_range(32, 256);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_span--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_t exp_char;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected transaction: cp=%h st=%0d adv=%0d dlv=%0b",
                                          out_data.code_point, out_data.status,
                                          out_data.advance_bytes, out_data.deliver));
            else
            begin
                exp_char = expected_chars.pop_front();
                if (out_data.code_point !== exp_char.code_point ||
                    out_data.status !== exp_char.status ||
                    out_data.advance_bytes !== exp_char.advance_bytes ||
                    out_data.deliver !== exp_char.deliver)
                    report_mismatch($sformatf(
                        "expected cp=%h st=%0d adv=%0d dlv=%0b, got cp=%h st=%0d adv=%0d dlv=%0b",
                        exp_char.code_point, exp_char.status, exp_char.advance_bytes,
                        exp_char.deliver, out_data.code_point, out_data.status,
                        out_data.advance_bytes, out_data.deliver));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_lossy_errors();
        test_random(1'b0, 280);
        test_backpressure();
        test_random(1'b1, 280);
        test_random(1'b0, 230);
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
